// File: sv/stk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, token codes and decode functions for the source tokenizer.
// No dependencies.
package stk_pkg;

  localparam logic [5:0] K_INT  = 6'd27;
  localparam logic [5:0] K_KW0  = 6'd28;
  localparam logic [5:0] K_ID   = 6'd36;
  localparam logic [5:0] K_END  = 6'd37;
  localparam logic [5:0] K_ERR  = 6'd38;
  localparam logic [5:0] K_NONE = 6'd63;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_UNTERM  = 3'd4;
  localparam logic [2:0] ST_UNEXPECT = 3'd5;

  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_INT  = 2'd1;
  localparam logic [1:0] W_CHAR = 2'd2;

  typedef struct packed {
    logic [5:0]  kind;
    logic [63:0] value;
    logic [15:0] start_off;
    logic [15:0] end_off;
    logic [2:0]  status;
    logic        last;
  } tok_t;

  // Up to two results per accepted byte.
  typedef struct packed {
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
  } push_t;

  function automatic tok_t make_tok(input logic [5:0] kind, input logic [63:0] value,
                                    input logic [15:0] s, input logic [15:0] e,
                                    input logic [2:0] st, input logic last);
    tok_t t;
    t.kind = kind;
    t.value = value;
    t.start_off = s;
    t.end_off = e;
    t.status = st;
    t.last = last;
    return t;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h21: k = 6'd0;
      8'h3D: k = 6'd2;
      8'h26: k = 6'd4;
      8'h7C: k = 6'd6;
      8'h5E: k = 6'd8;
      8'h7E: k = 6'd9;
      8'h3C: k = 6'd10;
      8'h3E: k = 6'd13;
      8'h2B: k = 6'd16;
      8'h2D: k = 6'd17;
      8'h2A: k = 6'd18;
      8'h2F: k = 6'd19;
      8'h25: k = 6'd20;
      8'h2C: k = 6'd21;
      8'h3B: k = 6'd22;
      8'h28: k = 6'd23;
      8'h29: k = 6'd24;
      8'h7B: k = 6'd25;
      8'h7D: k = 6'd26;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] c);
    logic [5:0] k;
    k = K_NONE;
    if (a == 8'h21 && c == 8'h3D) k = 6'd1;
    if (a == 8'h3D && c == 8'h3D) k = 6'd3;
    if (a == 8'h26 && c == 8'h26) k = 6'd5;
    if (a == 8'h7C && c == 8'h7C) k = 6'd7;
    if (a == 8'h3C && c == 8'h3D) k = 6'd11;
    if (a == 8'h3C && c == 8'h3C) k = 6'd12;
    if (a == 8'h3E && c == 8'h3D) k = 6'd14;
    if (a == 8'h3E && c == 8'h3E) k = 6'd15;
    return k;
  endfunction

  function automatic logic [7:0] esc_value(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      8'h30: v = 8'h00;
      8'h61: v = 8'h07;
      8'h62: v = 8'h08;
      8'h65: v = 8'h1B;
      8'h66: v = 8'h0C;
      8'h6E: v = 8'h0A;
      8'h72: v = 8'h0D;
      8'h74: v = 8'h09;
      default: v = c;
    endcase
    return v;
  endfunction

  // Keyword lookup on the packed prefix; falls back to identifier.
  function automatic logic [5:0] kw_kind(input logic [15:0] len, input logic [63:0] p);
    logic [5:0] k;
    k = K_ID;
    if (len == 16'd3 && p == 64'h6C6574)             k = K_KW0;
    if (len == 16'd2 && p == 64'h6966)               k = K_KW0 + 6'd1;
    if (len == 16'd4 && p == 64'h656C7365)           k = K_KW0 + 6'd2;
    if (len == 16'd5 && p == 64'h7768696C65)         k = K_KW0 + 6'd3;
    if (len == 16'd8 && p == 64'h636F6E74696E7565)   k = K_KW0 + 6'd4;
    if (len == 16'd5 && p == 64'h627265616B)         k = K_KW0 + 6'd5;
    if (len == 16'd6 && p == 64'h72657475726E)       k = K_KW0 + 6'd6;
    if (len == 16'd2 && p == 64'h666E)               k = K_KW0 + 6'd7;
    return k;
  endfunction

endpackage
`default_nettype wire

// File: sv/stk_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel interfaces for the source tokenizer: byte input and token output.
// No dependencies.
interface stk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface stk_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [63:0] token_value;
  logic [15:0] start_offset;
  logic [15:0] end_offset;
  logic [2:0]  status;
  logic        last_of_source;
  modport source (output valid, output token_kind, output token_value, output start_offset,
                  output end_offset, output status, output last_of_source, input ready);
  modport sink (input valid, input token_kind, input token_value, input start_offset,
                input end_offset, input status, input last_of_source, output ready);
endinterface
`default_nettype wire

// File: sv/stk_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Lexer front end: classifies one byte per cycle while room is high, emits up to two results.
// Depends on stk_pkg and stk_ifs.
module stk_front #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  stk_byte_if.sink           src,
  input  wire logic          room,
  output stk_pkg::push_t     push
);

  typedef enum logic [3:0] {
    M_IDLE, M_SYM, M_COMMENT, M_INT, M_CHAR_FIRST, M_CHAR_BODY, M_CHAR_ESC, M_IDENT,
    M_DRAIN
  } mode_t;

  mode_t                  mode, mode_next;
  logic [7:0]             pend, pend_next;
  logic [63:0]            acc, acc_next;
  logic [63:0]            pref, pref_next;
  logic [15:0]            len, len_next;
  logic [OFFSET_BITS-1:0] bpos, bpos_next;
  logic [OFFSET_BITS-1:0] tstart, tstart_next;
  logic [1:0]             warn, warn_next;

  logic                   acc_in;
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] nxt;
  logic [15:0]            p16, n16, t16;
  logic                   is_dig, is_alp;
  logic [5:0]             sk, pk, ik;
  logic [63:0]            mul10;
  logic [7:0]             app;
  logic                   do_app;
  // begin-of-token decode
  mode_t                  b_mode;
  logic                   b_emit;
  stk_pkg::tok_t          b_tok;
  logic                   use_beg, f_emit;
  stk_pkg::tok_t          f_tok;

  assign src.ready = room;
  assign acc_in = src.valid && room;
  assign c = src.char_byte;
  assign nxt = bpos + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  assign p16 = 16'(bpos);
  assign n16 = 16'(nxt);
  assign t16 = 16'(tstart);
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                  (c == 8'h5F);
  assign sk = stk_pkg::single_kind(c);
  assign pk = stk_pkg::pair_kind(pend, c);
  assign ik = stk_pkg::kw_kind(len, pref);
  assign mul10 = (acc << 3) + (acc << 1) + {60'd0, c[3:0]};

  always_comb begin
    mode_next = mode;
    pend_next = pend;
    acc_next = acc;
    pref_next = pref;
    len_next = len;
    tstart_next = tstart;
    warn_next = warn;
    b_mode = M_IDLE;
    b_emit = 1'b0;
    b_tok = '0;
    use_beg = 1'b0;
    f_emit = 1'b0;
    f_tok = '0;
    app = c;
    do_app = 1'b0;
    push = '0;

    case (mode)
      M_SYM: begin
        if (pk != stk_pkg::K_NONE) begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(pk, '0, t16, n16, stk_pkg::ST_OK, 1'b0);
          mode_next = M_IDLE;
        end else if (pend == 8'h2F && c == 8'h2A) begin
          pend_next = 8'd0;
          mode_next = M_COMMENT;
        end else begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(stk_pkg::single_kind(pend), '0, t16, p16,
                                    stk_pkg::ST_OK, 1'b0);
          use_beg = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == 8'd0) use_beg = 1'b1;
        else if (c == 8'h2F && pend != 8'd0) mode_next = M_IDLE;
        else pend_next = {7'd0, c == 8'h2A};
      end
      M_INT: begin
        if (is_dig) begin
          if (warn == stk_pkg::W_NONE && mul10 < acc) warn_next = stk_pkg::W_INT;
          acc_next = mul10;
        end else begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(stk_pkg::K_INT, acc, t16, p16, {1'b0, warn}, 1'b0);
          use_beg = 1'b1;
        end
      end
      M_CHAR_FIRST, M_CHAR_BODY: begin
        if (c == 8'h27 && mode == M_CHAR_FIRST) begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(stk_pkg::K_ERR, '0, t16, n16, stk_pkg::ST_EMPTY, 1'b1);
          mode_next = M_DRAIN;
        end else if (c == 8'h27) begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(stk_pkg::K_INT, acc, t16, n16, {1'b0, warn}, 1'b0);
          mode_next = M_IDLE;
        end else if (c == 8'd0) begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(stk_pkg::K_ERR, '0, t16, p16, stk_pkg::ST_UNTERM, 1'b1);
        end else if (c == 8'h5C) begin
          mode_next = M_CHAR_ESC;
        end else begin
          do_app = 1'b1;
        end
      end
      M_CHAR_ESC: begin
        if (c == 8'd0) begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(stk_pkg::K_ERR, '0, t16, p16, stk_pkg::ST_UNTERM, 1'b1);
        end else begin
          app = stk_pkg::esc_value(c);
          do_app = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alp || is_dig) begin
          if (len < 16'd8) pref_next = {pref[55:0], c};
          if (len != 16'hFFFF) len_next = len + 16'd1;
        end else begin
          f_emit = 1'b1;
          f_tok = stk_pkg::make_tok(ik, (ik == stk_pkg::K_ID) ? {48'd0, len} : 64'd0,
                                    t16, p16, stk_pkg::ST_OK, 1'b0);
          use_beg = 1'b1;
        end
      end
      M_DRAIN: ;
      default: use_beg = 1'b1;
    endcase

    if (do_app) begin
      if (warn == stk_pkg::W_NONE && acc[63:56] != 8'd0) warn_next = stk_pkg::W_CHAR;
      acc_next = {acc[55:0], app};
      mode_next = M_CHAR_BODY;
    end

    if (use_beg) begin
      if (c == 8'd0) begin
        b_emit = 1'b1;
        b_tok = stk_pkg::make_tok(stk_pkg::K_END, '0, p16, p16, stk_pkg::ST_OK, 1'b1);
      end else if (c == 8'h20 || c == 8'h09 || c == 8'h0A) begin
        b_mode = M_IDLE;
      end else begin
        tstart_next = bpos;
        if (c == 8'h21 || c == 8'h3D || c == 8'h26 || c == 8'h7C || c == 8'h3C ||
            c == 8'h3E || c == 8'h2F) begin
          pend_next = c;
          b_mode = M_SYM;
        end else if (sk != stk_pkg::K_NONE) begin
          b_emit = 1'b1;
          b_tok = stk_pkg::make_tok(sk, '0, p16, n16, stk_pkg::ST_OK, 1'b0);
        end else if (is_dig) begin
          acc_next = {60'd0, c[3:0]};
          warn_next = stk_pkg::W_NONE;
          b_mode = M_INT;
        end else if (c == 8'h27) begin
          acc_next = '0;
          warn_next = stk_pkg::W_NONE;
          b_mode = M_CHAR_FIRST;
        end else if (is_alp) begin
          pref_next = {56'd0, c};
          len_next = 16'd1;
          b_mode = M_IDENT;
        end else begin
          b_emit = 1'b1;
          b_tok = stk_pkg::make_tok(stk_pkg::K_ERR, '0, p16, n16, stk_pkg::ST_UNEXPECT, 1'b1);
          b_mode = M_DRAIN;
        end
      end
      mode_next = b_mode;
    end

    if (c == 8'd0) begin
      mode_next = M_IDLE;
      bpos_next = '0;
    end else begin
      bpos_next = nxt;
    end

    // pack results, flushed token first
    if (acc_in) begin
      if (f_emit) begin
        push.r0 = f_tok;
        push.r1 = b_tok;
        push.n = (use_beg && b_emit) ? 2'd2 : 2'd1;
      end else if (use_beg && b_emit) begin
        push.r0 = b_tok;
        push.n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= '0;
      acc <= '0;
      pref <= '0;
      len <= '0;
      bpos <= '0;
      tstart <= '0;
      warn <= '0;
    end else if (acc_in) begin
      mode <= mode_next;
      pend <= pend_next;
      acc <= acc_next;
      pref <= pref_next;
      len <= len_next;
      bpos <= bpos_next;
      tstart <= tstart_next;
      warn <= warn_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/stk_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: four-entry result queue and output register.
// Depends on stk_pkg and stk_ifs.
module stk_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire stk_pkg::push_t push,
  output logic                room,
  stk_tok_if.source           tok
);

  stk_pkg::tok_t mem [4];
  logic [1:0]    wr, rd;
  logic [2:0]    cnt;
  logic          ov;
  stk_pkg::tok_t obuf;
  logic          pop;

  assign room = (cnt <= 3'd2);
  assign pop = (cnt != 3'd0) && (!ov || tok.ready);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr] <= push.r0;
    if (push.n == 2'd2) mem[wr + 2'd1] <= push.r1;
    if (pop) obuf <= mem[rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      cnt <= '0;
      ov <= 1'b0;
    end else begin
      wr <= wr + push.n;
      if (pop) rd <= rd + 2'd1;
      cnt <= cnt + {1'b0, push.n} - {2'd0, pop};
      if (pop) ov <= 1'b1;
      else if (tok.ready) ov <= 1'b0;
    end
  end

  assign tok.valid = ov;
  assign tok.token_kind = obuf.kind;
  assign tok.token_value = obuf.value;
  assign tok.start_offset = obuf.start_off;
  assign tok.end_offset = obuf.end_off;
  assign tok.status = obuf.status;
  assign tok.last_of_source = obuf.last;

endmodule
`default_nettype wire

// File: sv/source_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Source tokenizer top level.
// Input channel src carries one source byte per request; byte 0 ends a source.
// Output channel tok carries one token per request with kind, value, start and
// end offsets, status and a last-of-source flag (END or an error result).
// A byte is lexed in the cycle it is accepted and its results (up to two)
// enter a four-entry queue; the first reaches tok through the output register.
// Throughput is one byte per cycle while each byte yields at most one token
// and tok is ready; the queue absorbs a byte that yields two tokens.
// src.ready drops while fewer than two queue entries are free, so a
// stalled tok holds its result and back-pressures src once three results
// wait in the queue; bytes that yield no token keep flowing until then.
// Tokens that need lookahead appear when the following byte arrives.
// After an error result, bytes are dropped up to and including byte 0.
// Synchronous reset empties the queue and returns the lexer to idle at
// offset 0.
// Depends on stk_pkg, stk_ifs, stk_front and stk_back.
module source_tokenizer_top #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  stk_byte_if.sink  src,
  stk_tok_if.source tok
);

  stk_pkg::push_t push;
  logic           room;

  stk_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk(clk), .rst(rst), .src(src), .room(room), .push(push)
  );

  stk_back u_back (
    .clk(clk), .rst(rst), .push(push), .room(room), .tok(tok)
  );

`ifndef ASSERT_OFF
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (src.valid && src.ready))
    else $error("results pushed without an accepted byte");
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> !push.r0.last)
    else $error("source-ending result followed by another");
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0 && push.r0.kind == stk_pkg::K_ERR) |-> push.r0.last)
    else $error("error result without last flag");
`endif

endmodule
`default_nettype wire
